// ===== rtl/core/lgs_pkg.sv =====
// Shared types, constants and the B3/S23 row rule for the life generation step unit.
// No dependencies; used by the top level and by its port checker.
package lgs_pkg;

  localparam int unsigned GRID_SIZE_DEF = 64;
  localparam int unsigned ROW_W         = 64;
  localparam int unsigned GEN_W         = 32;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned IDX_W         = 6;
  localparam int unsigned CFG_W         = 7;
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned APB_DW        = 32;

  // Stream payload layout
  localparam int unsigned IN_W       = 72;
  localparam int unsigned OUT_W      = 160;
  localparam int unsigned IN_OP_LO   = 0;
  localparam int unsigned IN_ROW_LO  = IN_OP_LO + OP_W;
  localparam int unsigned IN_BITS_LO = IN_ROW_LO + IDX_W;
  localparam int unsigned OUT_GEN_LO = 2 * ROW_W;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Register select from paddr[2]
  localparam logic REG_ACTIVE_ROWS = 1'b0;
  localparam logic REG_ACTIVE_COLS = 1'b1;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd50;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FETCH,
    ST_LOOKUP
  } lgs_state_t;

  // Next live bits of the middle row; all inputs already masked to the active columns.
  function automatic logic [ROW_W-1:0] life_row(input logic [ROW_W-1:0] up,
                                                input logic [ROW_W-1:0] mid,
                                                input logic [ROW_W-1:0] low,
                                                input logic [ROW_W-1:0] cmask);
    logic [ROW_W-1:0] up_l, up_r, mid_l, mid_r, low_l, low_r;
    logic [ROW_W-1:0] res;
    logic [3:0]       n;
    up_l  = up  << 1;
    up_r  = up  >> 1;
    mid_l = mid << 1;
    mid_r = mid >> 1;
    low_l = low << 1;
    low_r = low >> 1;
    for (int c = 0; c < ROW_W; c++) begin
      n = 4'(up_l[c]) + 4'(up[c]) + 4'(up_r[c]) + 4'(mid_l[c]) + 4'(mid_r[c])
        + 4'(low_l[c]) + 4'(low[c]) + 4'(low_r[c]);
      res[c] = cmask[c] & ((n == BIRTH_COUNT) | (mid[c] & (n == SURVIVE_COUNT)));
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/life_generation_step_unit.sv =====
// Top level of the life generation step unit: grid memories, sweep sequencer, APB registers.
// Depends on lgs_pkg.
//
// Conway B3/S23 grid engine. The grid lives in two synchronous memories of GRID_SIZE rows
// by 64 bits (live bits and sticky died marks), one row per word, with registered reads.
// Items arrive on the s_ stream; a generation step sweeps every row once through the
// memories, one row per cycle. Every item gives exactly one result on the m_ stream
// carrying the addressed row's live bits, its died marks and the generation count. One
// item is worked on at a time; the next is taken as soon as the previous result sits in
// the output register, even if the sink has not yet taken it. Cells outside active_rows x
// active_cols read and count as dead. Per-row valid flops stand in for clearing the
// memories after reset, so no clearing pass is needed. Write active_rows/active_cols only
// while the block is idle.
module life_generation_step_unit
  import lgs_pkg::*;
#(
  parameter int unsigned GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // APB register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  // Item stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // operation[1:0], row_index[7:2], row_bits[71:8]
  // Result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata    // alive_bits[63:0], died_bits[127:64],
                                       // generation[159:128]
);

  localparam int unsigned RW = $clog2(GRID_SIZE);
  localparam int unsigned CW = $clog2(GRID_SIZE + 2);

  // ---------------------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------------------
  logic [CFG_W-1:0] active_rows;
  logic [CFG_W-1:0] active_cols;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_rows <= ACTIVE_RESET;
      active_cols <= ACTIVE_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ACTIVE_COLS) active_cols <= pwdata[CFG_W-1:0];
      else                             active_rows <= pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_ACTIVE_COLS) ? APB_DW'(active_cols)
                                                : APB_DW'(active_rows);

  // Effective area, clipped to the grid
  logic [CFG_W-1:0] rows_eff;
  logic [CFG_W-1:0] cols_eff;
  logic [ROW_W-1:0] cmask;

  assign rows_eff = (active_rows > CFG_W'(GRID_SIZE)) ? CFG_W'(GRID_SIZE) : active_rows;
  assign cols_eff = (active_cols > CFG_W'(GRID_SIZE)) ? CFG_W'(GRID_SIZE) : active_cols;

  always_comb begin
    for (int c = 0; c < ROW_W; c++) begin
      cmask[c] = CFG_W'(c) < cols_eff;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Input fields
  // ---------------------------------------------------------------------------------------
  logic [OP_W-1:0]  in_op;
  logic [IDX_W-1:0] in_row;
  logic [ROW_W-1:0] in_bits;
  logic             in_range;
  logic [ROW_W-1:0] in_rmask;
  logic             s_xfer;

  assign in_op    = s_tdata[IN_ROW_LO-1:IN_OP_LO];
  assign in_row   = s_tdata[IN_BITS_LO-1:IN_ROW_LO];
  assign in_bits  = s_tdata[IN_W-1:IN_BITS_LO];
  assign in_range = CFG_W'(in_row) < CFG_W'(GRID_SIZE);
  assign in_rmask = (CFG_W'(in_row) < rows_eff) ? cmask : '0;
  assign s_xfer   = s_tvalid & s_tready;

  // ---------------------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------------------
  lgs_state_t       state, state_next;
  logic [CW-1:0]    cnt;         // sweep position: next row to read + 0, processes cnt-2
  logic [GEN_W-1:0] gen;
  logic [GRID_SIZE-1:0] live_vld;
  logic [GRID_SIZE-1:0] died_vld;

  logic [OP_W-1:0]  item_op;
  logic [IDX_W-1:0] item_row;
  logic [ROW_W-1:0] item_bits;

  // Sweep windows
  logic [ROW_W-1:0] win_up;
  logic [ROW_W-1:0] win_mid;
  logic [ROW_W-1:0] died_hold;   // died marks of the row in win_mid

  // Memories and their read registers
  logic [ROW_W-1:0] live_mem [GRID_SIZE];
  logic [ROW_W-1:0] died_mem [GRID_SIZE];
  logic [ROW_W-1:0] live_rd;
  logic [ROW_W-1:0] died_rd;
  logic             live_rd_ok;
  logic             died_rd_ok;

  // Memory control
  logic             rd_en;
  logic [RW-1:0]    rd_addr;
  logic             live_we;
  logic             died_we;
  logic [RW-1:0]    wr_addr;
  logic [ROW_W-1:0] live_wdata;
  logic [ROW_W-1:0] died_wdata;
  logic             out_load;

  // ---------------------------------------------------------------------------------------
  // Sweep datapath
  // ---------------------------------------------------------------------------------------
  logic [ROW_W-1:0] live_eff;
  logic [ROW_W-1:0] died_eff;
  logic [CFG_W-1:0] data_row;
  logic [CFG_W-1:0] proc_row;
  logic             data_ok;
  logic             proc_ok;
  logic [ROW_W-1:0] lower;
  logic [ROW_W-1:0] next_row;
  logic [ROW_W-1:0] died_calc;
  logic             sweep_first;
  logic             sweep_last;

  assign live_eff    = live_rd_ok ? live_rd : '0;
  assign died_eff    = died_rd_ok ? died_rd : '0;
  assign data_row    = CFG_W'(cnt) - CFG_W'(1);
  assign proc_row    = CFG_W'(cnt) - CFG_W'(2);
  assign data_ok     = data_row < rows_eff;   // false past the last row: bottom border
  assign proc_ok     = proc_row < rows_eff;
  assign lower       = data_ok ? (live_eff & cmask) : '0;
  assign next_row    = proc_ok ? life_row(win_up, win_mid, lower, cmask) : '0;
  assign died_calc   = proc_ok ? (win_mid & ~next_row) : '0;
  assign sweep_first = cnt == CW'(1);
  assign sweep_last  = cnt == CW'(GRID_SIZE + 1);

  // ---------------------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = (in_op == OP_STEP) ? ST_SWEEP : ST_LOOKUP;
      end
      ST_SWEEP: begin
        if (sweep_last) state_next = ST_FETCH;
      end
      ST_FETCH:  state_next = ST_LOOKUP;
      ST_LOOKUP: begin
        if (out_load) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = in_row[RW-1:0];
    live_we    = 1'b0;
    died_we    = 1'b0;
    wr_addr    = in_row[RW-1:0];
    live_wdata = in_bits & in_rmask;
    died_wdata = died_hold | died_calc;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          rd_en = 1'b1;
          if (in_op == OP_STEP) rd_addr = '0;
          if (in_op == OP_WRITE && in_range) live_we = 1'b1;
        end
      end
      ST_SWEEP: begin
        if (cnt < CW'(GRID_SIZE)) begin
          rd_en   = 1'b1;
          rd_addr = cnt[RW-1:0];
        end
        if (!sweep_first) begin
          live_we    = 1'b1;
          died_we    = 1'b1;
          wr_addr    = proc_row[RW-1:0];
          live_wdata = next_row;
        end
      end
      ST_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = item_row[RW-1:0];
      end
      ST_LOOKUP: out_load = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cnt      <= '0;
      gen      <= '0;
      live_vld <= '0;
      died_vld <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (s_xfer)                       cnt <= CW'(1);
      else if (state == ST_SWEEP)       cnt <= cnt + CW'(1);
      if (state == ST_SWEEP && sweep_last) gen <= gen + GEN_W'(1);
      if (live_we) live_vld[wr_addr] <= 1'b1;
      if (died_we) died_vld[wr_addr] <= 1'b1;
      if (out_load)      m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s_xfer) begin
      item_op   <= in_op;
      item_row  <= in_row;
      item_bits <= in_bits;
    end
    if (state == ST_SWEEP) begin
      died_hold <= died_eff;
      if (sweep_first) begin
        win_up  <= '0;
        win_mid <= lower;
      end else begin
        win_up  <= win_mid;
        win_mid <= lower;
      end
    end
    if (rd_en) begin
      live_rd_ok <= live_vld[rd_addr];
      died_rd_ok <= died_vld[rd_addr];
    end
  end

  // Live memory: one write, one read port
  always_ff @(posedge clk) begin
    if (live_we) live_mem[wr_addr] <= live_wdata;
    if (rd_en)   live_rd <= live_mem[rd_addr];
  end

  // Died-mark memory
  always_ff @(posedge clk) begin
    if (died_we) died_mem[wr_addr] <= died_wdata;
    if (rd_en)   died_rd <= died_mem[rd_addr];
  end

  // ---------------------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------------------
  logic             item_range;
  logic [ROW_W-1:0] item_rmask;
  logic [ROW_W-1:0] res_alive;
  logic [ROW_W-1:0] res_died;

  assign item_range = CFG_W'(item_row) < CFG_W'(GRID_SIZE);
  assign item_rmask = (CFG_W'(item_row) < rows_eff) ? cmask : '0;

  always_comb begin
    // a write shows its own masked bits; the live read of that cycle is stale
    res_alive = ((item_op == OP_WRITE) ? item_bits : live_eff) & item_rmask;
    res_died  = died_eff;
    if (!item_range) begin
      res_alive = '0;
      res_died  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= {gen, res_died, res_alive};
  end

endmodule

// ===== rtl/core/lgs_checker.sv =====
// Port-level checker for the life generation step unit, with its bind.
// Depends on lgs_pkg; attaches to life_generation_step_unit.
module lgs_checker
  import lgs_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic [IN_W-1:0]  s_tdata,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic [1:0]       pending;   // items taken but not yet delivered
  logic [GEN_W-1:0] gen_seen;  // steps taken so far
  logic             s_xfer;
  logic             m_xfer;

  assign s_xfer = s_tvalid & s_tready;
  assign m_xfer = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      gen_seen <= '0;
    end else begin
      pending <= pending + 2'(s_xfer) - 2'(m_xfer);
      if (s_xfer && s_tdata[IN_ROW_LO-1:IN_OP_LO] == OP_STEP) gen_seen <= gen_seen + GEN_W'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_xfer |-> pending <= 2'd1)
    else $error("item taken with more than one result outstanding");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 2'd0)
    else $error("result shown with no item outstanding");

  a_gen_count: assert property (@(posedge clk) disable iff (rst)
    m_xfer && pending == 2'd1 |-> m_tdata[OUT_W-1:OUT_GEN_LO] == gen_seen)
    else $error("generation does not match steps taken");

endmodule

bind life_generation_step_unit lgs_checker u_lgs_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
